/* rtl/sha1bs_pkg.sv */
// shared types and sizes for the sha-1 byte stream hasher
// used by sha1bs_compress and sha1_byte_stream_hasher_core; no dependencies
`default_nettype none

package sha1bs_pkg;

    // words in one message block and in the digest
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;

    // widths of the stream payloads
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // chaining value, element 0 is the most significant digest word
    typedef logic [DIGEST_WORDS-1:0][31:0] chain_t;

    // write request into the block memory
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } wr_req_t;

    // control from the sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic init;
    } ctl_t;

    // status back from the compression unit
    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/sha1bs_compress.sv */
// sha-1 compression unit: block word memories, 80-round datapath, chaining value
// depends on sha1bs_pkg
`default_nettype none

module sha1bs_compress (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sha1bs_pkg::wr_req_t wr_req,
    input  wire sha1bs_pkg::ctl_t  ctl,
    output sha1bs_pkg::sts_t       sts,
    output sha1bs_pkg::chain_t     chain
);
    import sha1bs_pkg::*;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_PRIME = 2'd1;
    localparam logic [1:0] C_ROUND = 2'd2;
    localparam logic [1:0] C_FOLD  = 2'd3;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] RND_20     = 7'd20;
    localparam logic [6:0] RND_40     = 7'd40;
    localparam logic [6:0] RND_60     = 7'd60;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam chain_t IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                             32'hefcdab89, 32'h67452301};

    // two copies of the block, so three schedule taps are read per cycle
    logic [31:0] mem_a [0:BLOCK_WORDS-1];
    logic [31:0] mem_b [0:BLOCK_WORDS-1];

    logic [1:0]  st_reg, st_next;
    logic [6:0]  t_reg, t_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] wd1_reg, wd2_reg, wd3_reg;
    logic [31:0] qa0_reg, qa1_reg, qb_reg;
    chain_t      chain_reg, chain_next;

    logic [3:0]  rd_base;
    logic [3:0]  ra0, ra1, rb;
    logic        sched;
    logic [31:0] w_mix, w_cur;
    logic [31:0] f_val, k_val, tmp_sum;
    logic        mem_we;
    logic [3:0]  mem_wa;
    logic [31:0] mem_wd;

    // read addresses for the round after this one: w[t], w[t-8], w[t-14]
    always_comb begin
        rd_base = (st_reg == C_ROUND) ? (t_reg[3:0] + 4'd1) : 4'd0;
        ra0     = rd_base;
        ra1     = rd_base + 4'd8;
        rb      = rd_base + 4'd2;
    end

    // message schedule, w[t-3] comes from the short delay line
    always_comb begin
        sched = (t_reg[6:4] != 3'd0);
        w_mix = qa0_reg ^ qa1_reg ^ qb_reg ^ wd3_reg;
        w_cur = sched ? {w_mix[30:0], w_mix[31]} : qa0_reg;
    end

    // round function and constant by quarter
    always_comb begin
        if (t_reg < RND_20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end else if (t_reg < RND_40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end else if (t_reg < RND_60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        tmp_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + k_val;
    end

    // memory write port: expanded schedule words during rounds, loads otherwise
    always_comb begin
        if ((st_reg == C_ROUND) && sched) begin
            mem_we = 1'b1;
            mem_wa = t_reg[3:0];
            mem_wd = w_cur;
        end else begin
            mem_we = wr_req.en;
            mem_wa = wr_req.addr;
            mem_wd = wr_req.data;
        end
    end

    // block memories with registered reads
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_a[mem_wa] <= mem_wd;
            mem_b[mem_wa] <= mem_wd;
        end
        qa0_reg <= mem_a[ra0];
        qa1_reg <= mem_a[ra1];
        qb_reg  <= mem_b[rb];
    end

    // sequencing and working variables
    always_comb begin
        st_next    = st_reg;
        t_next     = t_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        chain_next = chain_reg;
        case (st_reg)
            C_IDLE: begin
                if (ctl.start) begin
                    st_next = C_PRIME;
                    t_next  = 7'd0;
                end
            end
            C_PRIME: begin
                a_next  = chain_reg[0];
                b_next  = chain_reg[1];
                c_next  = chain_reg[2];
                d_next  = chain_reg[3];
                e_next  = chain_reg[4];
                st_next = C_ROUND;
            end
            C_ROUND: begin
                a_next = tmp_sum;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                t_next = t_reg + 7'd1;
                if (t_reg == LAST_ROUND) begin
                    st_next = C_FOLD;
                end
            end
            C_FOLD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                st_next       = C_IDLE;
            end
            default: begin
                st_next = C_IDLE;
            end
        endcase
        if (ctl.init) begin
            chain_next = IV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= C_IDLE;
            t_reg     <= 7'd0;
            chain_reg <= IV;
        end else begin
            st_reg    <= st_next;
            t_reg     <= t_next;
            chain_reg <= chain_next;
        end
    end

    // working variables and schedule delay line
    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        if (st_reg == C_ROUND) begin
            wd1_reg <= w_cur;
            wd2_reg <= wd1_reg;
            wd3_reg <= wd2_reg;
        end
    end

    assign sts.busy = (st_reg != C_IDLE);
    assign sts.done = (st_reg == C_FOLD);
    assign chain    = chain_reg;

    // loads from outside never collide with a running compression
    a_ext_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_req.en |-> (st_reg == C_IDLE))
        else $error("block write while compression runs");

    // priming always starts the rounds at zero
    a_prime_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == C_PRIME) |=> (st_reg == C_ROUND) && (t_reg == 7'd0))
        else $error("rounds did not start at zero");

    // the round after the last one folds, and folding returns to idle
    a_last_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == C_ROUND) && (t_reg == LAST_ROUND) |=> (st_reg == C_FOLD) ##1
        (st_reg == C_IDLE))
        else $error("fold sequence broken");

    // a start is only seen while idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> (st_reg == C_IDLE))
        else $error("start while busy");

endmodule

`default_nettype wire

/* rtl/sha1_byte_stream_hasher_core.sv */
// sha-1 over a byte stream: byte packing, padding, length and digest output
// depends on sha1bs_pkg and sha1bs_compress
//
//  channel  dir  ports                       contents
//  s_       in   tvalid tready tdata tuser   tdata[7:0] data_byte, tuser has_byte,
//                tlast                       tlast last
//  m_       out  tvalid tready tdata tlast   tdata[31:0] digest_word,
//                                            tdata[34:32] word_index, tlast last_word
//
// one byte is taken per cycle while a block fills; every 64th byte starts a
// compression (start, memory prime, 80 rounds at one per cycle, fold).
// closing a message takes up to 18 word writes of padding and length, one or two
// compressions, then five output items. aresetn clears all control state and
// loads the initial chaining value. no input item is taken while a compression,
// padding or the digest output is under way; the output holds under m_tready low.
`default_nettype none

module sha1_byte_stream_hasher_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sha1bs_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tuser,  // [0] has_byte
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sha1bs_pkg::M_TDATA_W-1:0]      m_tdata,  // [31:0] digest_word,
                                                            // [34:32] word_index
    output logic                                  m_tlast
);
    import sha1bs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CSTART = 3'd1;
    localparam logic [2:0] S_CWAIT  = 3'd2;
    localparam logic [2:0] S_PAD80  = 3'd3;
    localparam logic [2:0] S_PADZ   = 3'd4;
    localparam logic [2:0] S_LENHI  = 3'd5;
    localparam logic [2:0] S_LENLO  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam logic [1:0] AFT_IDLE  = 2'd0;
    localparam logic [1:0] AFT_PAD80 = 2'd1;
    localparam logic [1:0] AFT_PADZ  = 2'd2;
    localparam logic [1:0] AFT_OUT   = 2'd3;

    localparam logic [3:0] LEN_HI_IDX  = 4'd14;
    localparam logic [3:0] LEN_LO_IDX  = 4'd15;
    localparam logic [4:0] ZERO_END_1  = 5'd14;
    localparam logic [4:0] ZERO_END_2  = 5'd16;
    localparam logic [3:0] SECOND_FROM = 4'd14;
    localparam logic [2:0] LAST_OUT    = 3'(DIGEST_WORDS - 1);
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    logic [2:0]  st_reg, st_next;
    logic [1:0]  aft_reg, aft_next;
    logic [5:0]  fill_reg, fill_next;
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        second_reg, second_next;
    logic [4:0]  zptr_reg, zptr_next;
    logic [2:0]  ocnt_reg, ocnt_next;

    wr_req_t     wr_req;
    ctl_t        ctl;
    sts_t        core_sts;
    chain_t      chain;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] pad_word;
    logic        zero_done;

    sha1bs_compress u_compress (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (wr_req),
        .ctl     (ctl),
        .sts     (core_sts),
        .chain   (chain)
    );

    // handshakes
    assign s_tready = (st_reg == S_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign m_tvalid = (st_reg == S_OUT);
    assign out_acc  = m_tvalid & m_tready;

    // digest item
    assign m_tdata = {{(M_TDATA_W - 35){1'b0}}, ocnt_reg, chain[ocnt_reg]};
    assign m_tlast = (ocnt_reg == LAST_OUT);

    // closing word: gathered bytes, then the pad byte, then zeros
    always_comb begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg[23:0], PAD_BYTE};
        endcase
        zero_done = second_reg ? (zptr_reg == ZERO_END_2) : (zptr_reg >= ZERO_END_1);
    end

    // block memory writes
    always_comb begin
        wr_req = '0;
        case (st_reg)
            S_IDLE: begin
                if (in_acc && s_tuser && (fill_reg[1:0] == 2'd3)) begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = fill_reg[5:2];
                    wr_req.data = {acc_reg, s_tdata};
                end
            end
            S_PAD80: begin
                wr_req.en   = 1'b1;
                wr_req.addr = fill_reg[5:2];
                wr_req.data = pad_word;
            end
            S_PADZ: begin
                if (!zero_done) begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = zptr_reg[3:0];
                end
            end
            S_LENHI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = LEN_HI_IDX;
                wr_req.data = bitlen_reg[63:32];
            end
            S_LENLO: begin
                wr_req.en   = 1'b1;
                wr_req.addr = LEN_LO_IDX;
                wr_req.data = bitlen_reg[31:0];
            end
            default: begin
                wr_req = '0;
            end
        endcase
    end

    assign ctl.start = (st_reg == S_CSTART);
    assign ctl.init  = out_acc && (ocnt_reg == LAST_OUT);

    // message sequencer
    always_comb begin
        st_next     = st_reg;
        aft_next    = aft_reg;
        fill_next   = fill_reg;
        acc_next    = acc_reg;
        bitlen_next = bitlen_reg;
        second_next = second_reg;
        zptr_next   = zptr_reg;
        ocnt_next   = ocnt_reg;
        case (st_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        acc_next    = {acc_reg[15:0], s_tdata};
                        fill_next   = fill_reg + 6'd1;
                        bitlen_next = bitlen_reg + 64'd8;
                    end
                    if (s_tuser && (fill_reg == 6'd63)) begin
                        st_next  = S_CSTART;
                        aft_next = s_tlast ? AFT_PAD80 : AFT_IDLE;
                    end else if (s_tlast) begin
                        st_next = S_PAD80;
                    end
                end
            end
            S_CSTART: begin
                st_next = S_CWAIT;
            end
            S_CWAIT: begin
                if (core_sts.done) begin
                    case (aft_reg)
                        AFT_IDLE:  st_next = S_IDLE;
                        AFT_PAD80: st_next = S_PAD80;
                        AFT_PADZ:  st_next = S_PADZ;
                        default: begin
                            st_next   = S_OUT;
                            ocnt_next = 3'd0;
                        end
                    endcase
                end
            end
            S_PAD80: begin
                second_next = (fill_reg[5:2] >= SECOND_FROM);
                zptr_next   = {1'b0, fill_reg[5:2]} + 5'd1;
                st_next     = S_PADZ;
            end
            S_PADZ: begin
                if (!zero_done) begin
                    zptr_next = zptr_reg + 5'd1;
                end else if (second_reg) begin
                    second_next = 1'b0;
                    zptr_next   = 5'd0;
                    aft_next    = AFT_PADZ;
                    st_next     = S_CSTART;
                end else begin
                    st_next = S_LENHI;
                end
            end
            S_LENHI: begin
                st_next = S_LENLO;
            end
            S_LENLO: begin
                aft_next = AFT_OUT;
                st_next  = S_CSTART;
            end
            S_OUT: begin
                if (out_acc) begin
                    ocnt_next = ocnt_reg + 3'd1;
                    if (ocnt_reg == LAST_OUT) begin
                        st_next     = S_IDLE;
                        fill_next   = 6'd0;
                        bitlen_next = 64'd0;
                    end
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            aft_reg    <= AFT_IDLE;
            fill_reg   <= 6'd0;
            bitlen_reg <= 64'd0;
            second_reg <= 1'b0;
            zptr_reg   <= 5'd0;
            ocnt_reg   <= 3'd0;
        end else begin
            st_reg     <= st_next;
            aft_reg    <= aft_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            second_reg <= second_next;
            zptr_reg   <= zptr_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    // partial word bytes
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // input and output sides never active together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    // the compression unit only runs while the sequencer waits on it
    a_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        core_sts.busy |-> (st_reg == S_CWAIT))
        else $error("compression running outside wait");

    // after the final digest word the message state is back to empty
    a_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && (fill_reg == 6'd0) &&
        (bitlen_reg == 64'd0))
        else $error("state not cleared after digest");

endmodule

`default_nettype wire

/* sim/sha1_digest_checker.sv */
// checker for the sha-1 byte stream hasher: follows accepted input items, predicts
// the five digest words per message and compares them with the output channel
// depends on sha1bs_pkg for the stream widths and the block and digest sizes
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [sha1bs_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tuser,  // [0] has_byte
    input  wire logic                             s_tlast,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [sha1bs_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] digest_word,
                                                            // [34:32] word_index
    input  wire logic                             m_tlast,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    words_checked
);

    // one expected digest word as it should leave the block
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_word_t;

    localparam int LAST_IDX = sha1bs_pkg::DIGEST_WORDS - 1;

    // predictor state: chaining value, block being filled, fill level, bit count
    logic [31:0]  hash_h  [sha1bs_pkg::DIGEST_WORDS];
    logic [31:0]  msg_blk [sha1bs_pkg::BLOCK_WORDS];
    int           blk_fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_q [$];
    int           n_fail    = 0;
    int           n_pending = 0;
    int           n_checked = 0;

    assign fail_count    = n_fail;
    assign pending       = n_pending;
    assign words_checked = n_checked;

    // round constant for each group of twenty rounds
    function automatic logic [31:0] round_k(input int t);
        if (t < 20)      return 32'h5a827999;
        else if (t < 40) return 32'h6ed9eba1;
        else if (t < 60) return 32'h8f1bbcdc;
        else             return 32'hca62c1d6;
    endfunction

    // back to the start of a fresh message
    function automatic void clear_state();
        hash_h[0] = 32'h67452301;
        hash_h[1] = 32'hefcdab89;
        hash_h[2] = 32'h98badcfe;
        hash_h[3] = 32'h10325476;
        hash_h[4] = 32'hc3d2e1f0;
        foreach (msg_blk[i]) msg_blk[i] = '0;
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    // 80 rounds over the current block, folded into the chaining value
    function automatic void run_rounds();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, tmp, mix;
        int          s;
        foreach (w[i]) w[i] = msg_blk[i];
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int t = 0; t < 80; t++) begin
            s = t % 16;
            if (t >= 16) begin
                mix  = w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s];
                w[s] = {mix[30:0], mix[31]};
            end
            if (t < 20)      f = (b & c) | (~b & d);
            else if (t < 40) f = b ^ c ^ d;
            else if (t < 60) f = (b & c) | (b & d) | (c & d);
            else             f = b ^ c ^ d;
            tmp = {a[26:0], a[31:27]} + f + e + w[s] + round_k(t);
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
        foreach (msg_blk[i]) msg_blk[i] = '0;
        blk_fill = 0;
    endfunction

    // big-endian byte placement, compress on a full block
    function automatic void pack_byte(input logic [7:0] b);
        msg_blk[blk_fill / 4] |= {24'h0, b} << ((3 - blk_fill % 4) * 8);
        blk_fill++;
        if (blk_fill == 64) run_rounds();
    endfunction

    // one accepted input item; a closing item queues the digest
    function automatic void absorb_item(input logic [7:0] b, input logic has_b,
                                        input logic fin);
        if (has_b) begin
            pack_byte(b);
            msg_bits += 64'd8;
        end
        if (!fin) return;
        pack_byte(8'h80);
        if (blk_fill > 56) run_rounds();
        msg_blk[14] = msg_bits[63:32];
        msg_blk[15] = msg_bits[31:0];
        run_rounds();
        for (int k = 0; k < sha1bs_pkg::DIGEST_WORDS; k++)
            digest_q.push_back('{word: hash_h[k], idx: 3'(k), fin: (k == LAST_IDX)});
        clear_state();
    endfunction

    // sample both channels at the rising edge
    always @(posedge aclk) begin : watch_channels
        digest_word_t want;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected digest item, got word %h index %0d last %b",
                             $time, m_tdata[31:0], m_tdata[34:32], m_tlast);
                end else begin
                    want = digest_q.pop_front();
                    n_checked++;
                    if (m_tdata[31:0] !== want.word) begin
                        n_fail++;
                        $display("%0t: digest word mismatch, expected %h got %h",
                                 $time, want.word, m_tdata[31:0]);
                    end
                    if (m_tdata[34:32] !== want.idx) begin
                        n_fail++;
                        $display("%0t: word index mismatch, expected %0d got %0d",
                                 $time, want.idx, m_tdata[34:32]);
                    end
                    if (m_tlast !== want.fin) begin
                        n_fail++;
                        $display("%0t: last word flag mismatch, expected %b got %b",
                                 $time, want.fin, m_tlast);
                    end
                    if (m_tdata[sha1bs_pkg::M_TDATA_W-1:35] !== '0) begin
                        n_fail++;
                        $display("%0t: tdata fill bits mismatch, expected 0 got %h",
                                 $time, m_tdata[sha1bs_pkg::M_TDATA_W-1:35]);
                    end
                end
            end
            if (s_tvalid && s_tready) absorb_item(s_tdata[7:0], s_tuser, s_tlast);
        end
        n_pending = digest_q.size();
    end

endmodule

/* sim/sha1_byte_stream_hasher_core_test.sv */
// top of the sha-1 byte stream hasher testbench: clock, reset, input items and
// output stalls, watchdog and verdict
// depends on sha1bs_pkg, sha1_byte_stream_hasher_core and sha1_digest_checker
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_core_test;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_TAIL    = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sha1bs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [sha1bs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                             m_tlast;

    int fail_count;
    int pending;
    int words_checked;

    int items_sent = 0;
    int msgs_sent  = 0;
    int longest    = 0;
    int calm_from  = 32'h7fffffff;
    bit calm       = 1'b0;
    int stall_left = 0;
    int quiet      = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    sha1_byte_stream_hasher_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha1_digest_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // output stalls in random bursts, none in the calm tail
    always @(negedge aclk) begin
        if (calm) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet);
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // offer one input item from a falling edge, return at the falling edge after it is taken
    task automatic push_item(input logic [7:0] b, input logic has_b, input logic fin);
        int gap;
        items_sent++;
        if (items_sent >= calm_from) calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has_b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // a message of len random bytes with stray idle items, closed on its last byte
    // or by a separate empty close
    task automatic send_message(input int len);
        bit tail_byte;
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, tail_byte && (n == len - 1));
        end
        if (!tail_byte) push_item(8'($urandom), 1'b0, 1'b1);
        msgs_sent++;
        if (len > longest) longest = len;
    endtask

    initial begin
        int pick;
        int random_end;

        // reset, then start driving on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // idle item that must change nothing
        push_item(8'ha5, 1'b0, 1'b0);
        // empty message
        push_item(8'h00, 1'b0, 1'b1);
        // "abc", closed on its last byte
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // byte extremes with an idle item inside, then an empty close
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1);
        // single-byte messages
        push_item(8'h80, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        msgs_sent += 5;
        longest = 3;

        // hold off until every digest so far has come out
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);

        // random part: the one- and two-compression padding limits first
        random_end = items_sent + RANDOM_ITEMS;
        calm_from  = random_end - CALM_TAIL;
        send_message(55);
        send_message(56);
        while (items_sent < random_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)      send_message($urandom_range(0, 12));
            else if (pick < 92) send_message($urandom_range(55, 64));
            else                send_message($urandom_range(119, 128));
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d input items in %0d messages, longest %0d bytes",
                 items_sent, msgs_sent, longest);
        $display("checked %0d digest words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
